>>> src/chacha_pkg.sv
// Shared types, register indexes and state-word setup for the ChaCha20 stream XOR block.
// No dependencies; every other file in src imports this package.
package chacha_pkg;

  localparam int WORD_W  = 32;
  localparam int CFG_W   = 64;
  localparam int IDX_W   = 3;

  localparam logic [WORD_W-1:0] SIGMA_0 = 32'h6170_7865;
  localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320_646E;
  localparam logic [WORD_W-1:0] SIGMA_2 = 32'h7962_2D32;
  localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6B20_6574;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_KEY_PART_0    = 3'd0;
  localparam logic [IDX_W-1:0] REG_KEY_PART_1    = 3'd1;
  localparam logic [IDX_W-1:0] REG_KEY_PART_2    = 3'd2;
  localparam logic [IDX_W-1:0] REG_KEY_PART_3    = 3'd3;
  localparam logic [IDX_W-1:0] REG_NONCE_LOW     = 3'd4;
  localparam logic [IDX_W-1:0] REG_NONCE_HIGH    = 3'd5;
  localparam logic [IDX_W-1:0] REG_INITIAL_COUNT = 3'd6;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [3:0][WORD_W-1:0] row_t;

  typedef struct packed {
    logic [255:0] key;
    logic [95:0]  nonce;
    word_t        init_ctr;
  } cfg_t;

  // Word idx of the 16-word input state.
  function automatic word_t init_word(input cfg_t c, input word_t ctr, input logic [3:0] idx);
    word_t w;
    unique case (idx)
      4'd0:  w = SIGMA_0;
      4'd1:  w = SIGMA_1;
      4'd2:  w = SIGMA_2;
      4'd3:  w = SIGMA_3;
      4'd4:  w = c.key[31:0];
      4'd5:  w = c.key[63:32];
      4'd6:  w = c.key[95:64];
      4'd7:  w = c.key[127:96];
      4'd8:  w = c.key[159:128];
      4'd9:  w = c.key[191:160];
      4'd10: w = c.key[223:192];
      4'd11: w = c.key[255:224];
      4'd12: w = ctr;
      4'd13: w = c.nonce[31:0];
      4'd14: w = c.nonce[63:32];
      4'd15: w = c.nonce[95:64];
      default: w = '0;
    endcase
    return w;
  endfunction

  // Rotate a row of four words left by n word positions.
  function automatic row_t rot_row(input row_t r, input logic [1:0] n);
    row_t o;
    for (int i = 0; i < 4; i++) begin
      o[i] = r[2'(i) + n];
    end
    return o;
  endfunction

endpackage

>>> src/chacha20_stream_xor_top.sv
// ChaCha20 stream XOR top level: sequencer, 16-word state and byte output register.
// Depends on chacha_pkg, chacha_cfg and chacha_arx.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-------------------------------------------
//  s_*     | in  | s_tvalid / s_tready | s_tdata data_byte, s_tuser first, s_tlast
//  m_*     | out | m_tvalid / m_tready | m_tdata out_byte, m_tlast last_out
//  cfg_*   | in  | cfg_we              | cfg_index, cfg_data (64 bits)
//
// A byte inside a held keystream block is emitted straight from idle. A byte that opens a block
// (position 0, first flag, or after reset) goes through a load step, the shared add-xor-rotate
// unit (one step per cycle, 80 quarter rounds), 16 final word adds on the same adder, and
// a register stage for the result.
// Reset is synchronous; no clearing pass. A stalled output blocks new input transactions.
module chacha20_stream_xor_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] data_byte
  input  logic                          s_tuser,   // [0] first_of_message
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // [7:0] out_byte
  output logic                          m_tlast,
  input  logic                          cfg_we,
  input  logic [chacha_pkg::IDX_W-1:0]  cfg_index,
  input  logic [chacha_pkg::CFG_W-1:0]  cfg_data
);
  import chacha_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_FINAL = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  localparam logic [8:0] ROUND_LAST = 9'd319;

  cfg_t   cfg;
  state_t state;
  logic [8:0]  cnt;
  logic [5:0]  pos;
  logic        blk_ready;
  word_t       blk_ctr;
  logic [15:0][WORD_W-1:0] w;
  logic [15:0][WORD_W-1:0] w_next;
  logic [7:0]  data_r;
  logic        last_r;

  logic        s_acc;
  logic        out_free;
  logic        need_build;
  word_t       ctr_eff;
  logic [7:0]  ks_byte;
  logic        emit_now;
  logic        do_emit;
  logic [7:0]  emit_data;
  logic        emit_last;

  word_t       arx_x;
  word_t       arx_y;
  word_t       arx_z;
  word_t       arx_sum;
  word_t       arx_mix;
  logic [1:0]  step;
  logic [1:0]  col;
  logic        half;

  chacha_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign step = cnt[1:0];
  assign col  = cnt[3:2];
  assign half = cnt[4];

  always_comb begin
    if (state == ST_FINAL) begin
      arx_x = w[0];
      arx_y = init_word(cfg, blk_ctr, cnt[3:0]);
      arx_z = w[12];
    end else if (step[0]) begin
      arx_x = w[8];
      arx_y = w[12];
      arx_z = w[4];
    end else begin
      arx_x = w[0];
      arx_y = w[4];
      arx_z = w[12];
    end
  end

  chacha_arx u_arx (
    .x    (arx_x),
    .y    (arx_y),
    .z    (arx_z),
    .step (step),
    .sum  (arx_sum),
    .mix  (arx_mix)
  );

  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = (state == ST_IDLE) && out_free;
  assign s_acc      = s_tvalid && s_tready;
  assign need_build = s_tuser || (pos == 6'd0) || !blk_ready;
  assign ctr_eff    = s_tuser ? cfg.init_ctr : blk_ctr;
  assign ks_byte    = w[0][{pos[1:0], 3'b000} +: 8];

  // Emit straight from idle when the keystream is held, else after the build
  assign emit_now  = s_acc && !need_build;
  assign do_emit   = emit_now || ((state == ST_EMIT) && out_free);
  assign emit_data = (state == ST_EMIT) ? data_r : s_tdata;
  assign emit_last = (state == ST_EMIT) ? last_r : s_tlast;

  always_comb begin
    w_next = w;
    if ((state == ST_IDLE) && s_acc && need_build) begin
      for (int i = 0; i < 16; i++) begin
        w_next[i] = init_word(cfg, ctr_eff, 4'(i));
      end
    end else if (state == ST_ROUND) begin
      if (step[0]) begin
        w_next[8] = arx_sum;
        w_next[4] = arx_mix;
      end else begin
        w_next[0]  = arx_sum;
        w_next[12] = arx_mix;
      end
      // Advance to the next column; at a half boundary also enter or leave diagonal form
      if (step == 2'd3) begin
        if ((col == 2'd3) && !half) begin
          w_next[3:0]   = rot_row(w_next[3:0], 2'd1);
          w_next[7:4]   = rot_row(w_next[7:4], 2'd2);
          w_next[11:8]  = rot_row(w_next[11:8], 2'd3);
          w_next[15:12] = rot_row(w_next[15:12], 2'd0);
        end else if ((col == 2'd3) && half) begin
          w_next[3:0]   = rot_row(w_next[3:0], 2'd1);
          w_next[7:4]   = rot_row(w_next[7:4], 2'd0);
          w_next[11:8]  = rot_row(w_next[11:8], 2'd3);
          w_next[15:12] = rot_row(w_next[15:12], 2'd2);
        end else begin
          w_next[3:0]   = rot_row(w_next[3:0], 2'd1);
          w_next[7:4]   = rot_row(w_next[7:4], 2'd1);
          w_next[11:8]  = rot_row(w_next[11:8], 2'd1);
          w_next[15:12] = rot_row(w_next[15:12], 2'd1);
        end
      end
    end else if (state == ST_FINAL) begin
      // Shift the block through word 0 and add the input state on the way around
      for (int i = 0; i < 15; i++) begin
        w_next[i] = w[i+1];
      end
      w_next[15] = arx_sum;
    end else if (do_emit && (pos[1:0] == 2'd3)) begin
      // Word 0 is used up: bring the next keystream word forward
      for (int i = 0; i < 15; i++) begin
        w_next[i] = w[i+1];
      end
      w_next[15] = w[0];
    end
  end

  always_ff @(posedge clk) begin
    w <= w_next;
    if (s_acc) begin
      data_r <= s_tdata;
      last_r <= s_tlast;
    end
    if (do_emit) begin
      m_tdata <= emit_data ^ ks_byte;
      m_tlast <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      pos       <= '0;
      blk_ready <= 1'b0;
      blk_ctr   <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (do_emit) begin
        m_tvalid <= 1'b1;
        pos      <= pos + 6'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_acc && need_build) begin
            blk_ctr   <= ctr_eff;
            blk_ready <= 1'b0;
            if (s_tuser) begin
              pos <= '0;
            end
            cnt   <= '0;
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          if (cnt == ROUND_LAST) begin
            cnt   <= '0;
            state <= ST_FINAL;
          end else begin
            cnt <= cnt + 9'd1;
          end
        end
        ST_FINAL: begin
          if (cnt[3:0] == 4'd15) begin
            cnt       <= '0;
            blk_ctr   <= blk_ctr + 32'd1;
            blk_ready <= 1'b1;
            state     <= ST_EMIT;
          end else begin
            cnt <= cnt + 9'd1;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> src/chacha_cfg.sv
// Configuration register file: key, nonce and initial block counter.
// Depends on chacha_pkg.
module chacha_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [chacha_pkg::IDX_W-1:0]  cfg_index,
  input  logic [chacha_pkg::CFG_W-1:0]  cfg_data,
  output chacha_pkg::cfg_t              cfg
);
  import chacha_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_PART_0:    cfg.key[63:0]    <= cfg_data;
        REG_KEY_PART_1:    cfg.key[127:64]  <= cfg_data;
        REG_KEY_PART_2:    cfg.key[191:128] <= cfg_data;
        REG_KEY_PART_3:    cfg.key[255:192] <= cfg_data;
        REG_NONCE_LOW:     cfg.nonce[63:0]  <= cfg_data;
        REG_NONCE_HIGH:    cfg.nonce[95:64] <= cfg_data[31:0];
        REG_INITIAL_COUNT: cfg.init_ctr     <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

endmodule

>>> src/chacha_arx.sv
// Shared add-xor-rotate unit: sum = x + y, mix = rotl(z ^ sum, r) with r set by the step.
// Depends on chacha_pkg.
module chacha_arx (
  input  chacha_pkg::word_t x,
  input  chacha_pkg::word_t y,
  input  chacha_pkg::word_t z,
  input  logic [1:0]        step,
  output chacha_pkg::word_t sum,
  output chacha_pkg::word_t mix
);
  import chacha_pkg::*;

  word_t t;

  assign sum = x + y;
  assign t   = z ^ sum;

  // Quarter-round steps rotate by 16, 12, 8 and 7
  always_comb begin
    unique case (step)
      2'd0: mix = {t[15:0], t[31:16]};
      2'd1: mix = {t[19:0], t[31:20]};
      2'd2: mix = {t[23:0], t[31:24]};
      2'd3: mix = {t[24:0], t[31:25]};
      default: mix = t;
    endcase
  end

endmodule

>>> tb/tb_chacha20_stream_xor_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for chacha20_stream_xor_top: drives byte streams with random
// flow control and checks every output byte against a ChaCha20 keystream predictor.
// Depends on chacha_pkg (register indexes and port widths) and the block under test.

typedef struct packed {
  logic [7:0] value;
  logic       last;
} cipher_byte_t;

class chacha_xor_scoreboard;
  bit [63:0] key_regs [4];
  bit [63:0] nonce_lo;
  bit [31:0] nonce_hi;
  bit [31:0] start_ctr;

  bit [31:0] ks_words [16];
  bit [31:0] wk [16];
  bit [31:0] blk_ctr;
  bit [5:0]  pos;
  bit        have_block;

  cipher_byte_t expected_bytes [$];
  int errors;
  int results_checked;
  int blocks_built;
  int ctr_wraps;
  int msg_starts;

  function void set_register(logic [chacha_pkg::IDX_W-1:0] idx, logic [63:0] val);
    case (idx)
      chacha_pkg::REG_KEY_PART_0:    key_regs[0] = val;
      chacha_pkg::REG_KEY_PART_1:    key_regs[1] = val;
      chacha_pkg::REG_KEY_PART_2:    key_regs[2] = val;
      chacha_pkg::REG_KEY_PART_3:    key_regs[3] = val;
      chacha_pkg::REG_NONCE_LOW:     nonce_lo = val;
      chacha_pkg::REG_NONCE_HIGH:    nonce_hi = val[31:0];
      chacha_pkg::REG_INITIAL_COUNT: start_ctr = val[31:0];
      default: ;
    endcase
  endfunction

  function bit [31:0] rotl(bit [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function void quarter(int a, int b, int c, int d);
    wk[a] += wk[b]; wk[d] = rotl(wk[d] ^ wk[a], 16);
    wk[c] += wk[d]; wk[b] = rotl(wk[b] ^ wk[c], 12);
    wk[a] += wk[b]; wk[d] = rotl(wk[d] ^ wk[a], 8);
    wk[c] += wk[d]; wk[b] = rotl(wk[b] ^ wk[c], 7);
  endfunction

  function void build_keystream_block();
    bit [31:0] init [16];
    init[0]  = 32'h6170_7865;
    init[1]  = 32'h3320_646E;
    init[2]  = 32'h7962_2D32;
    init[3]  = 32'h6B20_6574;
    for (int i = 0; i < 4; i++) begin
      init[4 + 2*i] = key_regs[i][31:0];
      init[5 + 2*i] = key_regs[i][63:32];
    end
    init[12] = blk_ctr;
    init[13] = nonce_lo[31:0];
    init[14] = nonce_lo[63:32];
    init[15] = nonce_hi;
    for (int i = 0; i < 16; i++) wk[i] = init[i];
    for (int r = 0; r < 10; r++) begin
      quarter(0, 4, 8, 12);
      quarter(1, 5, 9, 13);
      quarter(2, 6, 10, 14);
      quarter(3, 7, 11, 15);
      quarter(0, 5, 10, 15);
      quarter(1, 6, 11, 12);
      quarter(2, 7, 8, 13);
      quarter(3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) ks_words[i] = wk[i] + init[i];
    blk_ctr++;
    if (blk_ctr == 0) ctr_wraps++;
    have_block = 1;
    blocks_built++;
  endfunction

  // Predict the output for one accepted input transaction.
  function void note_input(logic [7:0] data, logic first, logic last);
    bit [31:0] word;
    cipher_byte_t exp_b;
    if (first) begin
      blk_ctr = start_ctr;
      pos = 0;
      have_block = 0;
      msg_starts++;
    end
    if (pos == 0 || !have_block) build_keystream_block();
    word = ks_words[pos[5:2]] >> {pos[1:0], 3'b000};
    exp_b.value = data ^ word[7:0];
    exp_b.last = last;
    expected_bytes.push_back(exp_b);
    pos++;
  endfunction

  function void check_result(logic [7:0] value, logic last);
    cipher_byte_t exp_b;
    results_checked++;
    if (expected_bytes.size() == 0) begin
      errors++;
      $display("%0t: unexpected output byte %02h last %0b", $time, value, last);
      return;
    end
    exp_b = expected_bytes.pop_front();
    if (value !== exp_b.value) begin
      errors++;
      $display("%0t: out_byte mismatch, expected %02h actual %02h", $time,
               exp_b.value, value);
    end
    if (last !== exp_b.last) begin
      errors++;
      $display("%0t: last_out mismatch, expected %0b actual %0b", $time,
               exp_b.last, last);
    end
  endfunction
endclass

module tb_chacha20_stream_xor_top;
  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [7:0]                    s_tdata = '0;   // [7:0] data_byte
  logic                          s_tuser = 1'b0; // [0] first_of_message
  logic                          s_tlast = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [7:0]                    m_tdata;        // [7:0] out_byte
  logic                          m_tlast;
  logic                          cfg_we = 1'b0;
  logic [chacha_pkg::IDX_W-1:0]  cfg_index = '0;
  logic [chacha_pkg::CFG_W-1:0]  cfg_data = '0;

  chacha_xor_scoreboard sb = new();
  int bytes_sent = 0;
  bit long_hold_done = 0;

  chacha20_stream_xor_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random ready pattern, plus one long hold-off so the block backs up.
  initial begin
    int run_len;
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (!long_hold_done && sb.results_checked >= 150) begin
        long_hold_done = 1;
        m_tready <= 1'b0;
        repeat (1200) @(posedge clk);
      end else begin
        run_len = $urandom_range(1, 24);
        gap = pick_gap();
        m_tready <= 1'b1;
        repeat (run_len) @(posedge clk);
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Write all seven registers back to back; the block must be idle.
  task automatic program_cipher(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                                logic [63:0] k3, logic [63:0] n_lo, logic [31:0] n_hi,
                                logic [31:0] ctr);
    logic [chacha_pkg::IDX_W-1:0] idx [7];
    logic [63:0] val [7];
    idx[0] = chacha_pkg::REG_KEY_PART_0;    val[0] = k0;
    idx[1] = chacha_pkg::REG_KEY_PART_1;    val[1] = k1;
    idx[2] = chacha_pkg::REG_KEY_PART_2;    val[2] = k2;
    idx[3] = chacha_pkg::REG_KEY_PART_3;    val[3] = k3;
    idx[4] = chacha_pkg::REG_NONCE_LOW;     val[4] = n_lo;
    idx[5] = chacha_pkg::REG_NONCE_HIGH;    val[5] = {32'h0, n_hi};
    idx[6] = chacha_pkg::REG_INITIAL_COUNT; val[6] = {32'h0, ctr};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      sb.set_register(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_byte(logic [7:0] data, logic first, logic last);
    int gap;
    s_tdata <= data;
    s_tuser <= first;
    s_tlast <= last;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(data, first, last);
    bytes_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every predicted byte has come back.
  task automatic drain_output();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_bytes.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed messages; about one in ten gets random flags.
  task automatic run_messages(int n_items, int forced_len);
    int sent;
    int len;
    bit noisy;
    logic first;
    logic last;
    sent = 0;
    while (sent < n_items) begin
      if (forced_len > 0 && sent == 0) len = forced_len;
      else if ($urandom_range(0, 99) < 85) len = $urandom_range(1, 24);
      else len = $urandom_range(40, 140);
      noisy = ($urandom_range(0, 9) == 0) && !(forced_len > 0 && sent == 0);
      for (int i = 0; i < len; i++) begin
        if (noisy) begin
          first = 1'($urandom_range(0, 1));
          last = ($urandom_range(0, 3) == 0);
        end else begin
          first = (i == 0);
          last = (i == len - 1);
        end
        send_byte(8'($urandom_range(0, 255)), first, last);
      end
      sent += len;
    end
  endtask

  initial begin
    logic [63:0] rk [4];
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    program_cipher(64'h0706050403020100, 64'h0F0E0D0C0B0A0908, 64'h1716151413121110,
                   64'h1F1E1D1C1B1A1918, 64'h4A00000000000000, 32'h0, 32'h1);
    // No first flag yet: stream starts from counter zero
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h5A, 1'b0, 1'b1);
    // Last flag only passes through; keystream continues
    send_byte(8'hA5, 1'b0, 1'b0);
    send_byte(8'h80, 1'b1, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'hFE, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h7F, 1'b1, 1'b1);
    // First flag in mid-block drops the held keystream
    send_byte(8'h3C, 1'b1, 1'b0);
    send_byte(8'hC3, 1'b0, 1'b0);
    send_byte(8'h0F, 1'b1, 1'b0);
    send_byte(8'hF0, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    drain_output();

    program_cipher('0, '0, '0, '0, '0, 32'h0, 32'h0);
    run_messages(50, 0);
    drain_output();

    // All ones; the counter wraps inside the first message
    program_cipher('1, '1, '1, '1, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_messages(75, 70);
    drain_output();

    for (int i = 0; i < 4; i++) rk[i] = {$urandom, $urandom};
    program_cipher(rk[0], rk[1], rk[2], rk[3], {$urandom, $urandom}, $urandom, $urandom);
    run_messages(20, 0);
    drain_output();
    run_messages(20, 0);
    drain_output();

    for (int i = 0; i < 4; i++) rk[i] = {$urandom, $urandom};
    program_cipher(rk[0], rk[1], rk[2], rk[3], {$urandom, $urandom}, $urandom,
                   32'hFFFF_FFFE);
    run_messages(95, 130);
    drain_output();

    repeat (400) @(posedge clk);
    if (sb.expected_bytes.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d output bytes never arrived", $time, sb.expected_bytes.size());
    end
    $display("Sent %0d bytes in %0d messages; %0d keystream blocks, %0d counter wraps.",
             bytes_sent, sb.msg_starts, sb.blocks_built, sb.ctr_wraps);
    $display("Checked %0d output bytes, %0d errors.", sb.results_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Run timed out");
    $display("Test completed with failures");
    $finish;
  end
endmodule

>>> sim.f
src/chacha_pkg.sv
src/chacha_cfg.sv
src/chacha_arx.sv
src/chacha20_stream_xor_top.sv
tb/tb_chacha20_stream_xor_top.sv
